/* rtl/crfu_pkg.sv */
// ----------------------------------------------------------------------------
// crfu_pkg
// Types, codes and helpers shared by the register/flag unit.
// ----------------------------------------------------------------------------
package crfu_pkg;

  typedef enum logic [4:0] {
    CMD_NOP       = 5'd0,
    CMD_XBA       = 5'd1,
    CMD_XCE       = 5'd2,
    CMD_REP       = 5'd3,
    CMD_SEP       = 5'd4,
    CMD_CLC       = 5'd5,
    CMD_SEC       = 5'd6,
    CMD_CLI       = 5'd7,
    CMD_SEI       = 5'd8,
    CMD_CLV       = 5'd9,
    CMD_CLD       = 5'd10,
    CMD_SED       = 5'd11,
    CMD_XFER_BYTE = 5'd12,
    CMD_XFER_WORD = 5'd13,
    CMD_TCS       = 5'd14,
    CMD_TSX_BYTE  = 5'd15,
    CMD_TSX_WORD  = 5'd16,
    CMD_TXS       = 5'd17,
    CMD_WRITE     = 5'd18
  } cmd_e;

  typedef enum logic [2:0] {
    REG_A  = 3'd0,
    REG_X  = 3'd1,
    REG_Y  = 3'd2,
    REG_S  = 3'd3,
    REG_D  = 3'd4,
    REG_DB = 3'd5
  } reg_sel_e;

  // status bit positions
  localparam int unsigned FlagC = 0;
  localparam int unsigned FlagZ = 1;
  localparam int unsigned FlagI = 2;
  localparam int unsigned FlagD = 3;
  localparam int unsigned FlagX = 4;
  localparam int unsigned FlagV = 6;
  localparam int unsigned FlagN = 7;

  localparam logic [7:0]  ModeFlagMask = 8'h30;  // M and X
  localparam logic [7:0]  EmuStackPage = 8'h01;

  localparam logic [15:0] ResetS = 16'h01FF;
  localparam logic [7:0]  ResetP = 8'h34;

  typedef struct packed {
    logic [4:0]  cmd;
    logic [7:0]  operand_byte;
    logic [2:0]  source_reg;
    logic [2:0]  dest_reg;
    logic [15:0] write_value;
  } in_item_t;

  typedef struct packed {
    logic [15:0] acc;
    logic [15:0] index_x;
    logic [15:0] index_y;
    logic [15:0] stack_ptr;
    logic [15:0] direct_page;
    logic [7:0]  data_bank;
    logic [7:0]  status;
    logic        emulation;
  } out_item_t;

  function automatic logic reg_sel_ok(logic [2:0] sel);
    return sel <= REG_DB;
  endfunction

  function automatic logic [15:0] read_reg(out_item_t r, logic [2:0] sel);
    logic [15:0] v;
    case (sel)
      REG_A:   v = r.acc;
      REG_X:   v = r.index_x;
      REG_Y:   v = r.index_y;
      REG_S:   v = r.stack_ptr;
      REG_D:   v = r.direct_page;
      default: v = {8'h00, r.data_bank};
    endcase
    return v;
  endfunction

  function automatic out_item_t write_reg(out_item_t r, logic [2:0] sel, logic [15:0] v);
    out_item_t n;
    n = r;
    case (sel)
      REG_A:   n.acc         = v;
      REG_X:   n.index_x     = v;
      REG_Y:   n.index_y     = v;
      REG_S:   n.stack_ptr   = v;
      REG_D:   n.direct_page = v;
      default: n.data_bank   = v[7:0];
    endcase
    return n;
  endfunction

endpackage

/* rtl/cpu_register_flag_unit.sv */
// ----------------------------------------------------------------------------
// cpu_register_flag_unit
// Register-transfer and status unit for a 65816-style core.
// ----------------------------------------------------------------------------
//  channel | direction | handshake               | payload
//  in      | input     | in_valid_i / in_stall_o   | crfu_pkg::in_item_t
//  out     | output    | out_valid_o / out_stall_i | crfu_pkg::out_item_t
//
//  The accepting edge loads the input register; once the item advances,
//  the next-state result is written into the register file, which
//  drives the result from then on.
//  One transaction per cycle is sustained while out_stall_i stays low.
//  Reset sets A/X/Y/D/DB to 0, S to 0x01FF, P to 0x34 and E to 1.
//  A stalled result holds the registers; one more item waits in the
//  input register before in_stall_o rises.
// ----------------------------------------------------------------------------
module cpu_register_flag_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  crfu_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output crfu_pkg::out_item_t out_data_o
);

  logic                in_valid_q;
  crfu_pkg::in_item_t  in_item_q;
  logic                out_valid_q;
  crfu_pkg::out_item_t state_q;
  crfu_pkg::out_item_t state_d;
  logic                advance;
  logic                load_in;

  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign load_in    = in_valid_i && !in_stall_o;

  crfu_exec u_exec (
    .item_i (in_item_q),
    .cur_i  (state_q),
    .nxt_o  (state_d)
  );

  always_ff @(posedge clk_i) begin
    if (load_in) begin
      in_item_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q            <= 1'b0;
      out_valid_q           <= 1'b0;
      state_q.acc           <= 16'h0000;
      state_q.index_x       <= 16'h0000;
      state_q.index_y       <= 16'h0000;
      state_q.stack_ptr     <= crfu_pkg::ResetS;
      state_q.direct_page   <= 16'h0000;
      state_q.data_bank     <= 8'h00;
      state_q.status        <= crfu_pkg::ResetP;
      state_q.emulation     <= 1'b1;
    end else begin
      if (load_in) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        state_q     <= state_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = state_q;

endmodule

/* rtl/crfu_exec.sv */
// ----------------------------------------------------------------------------
// crfu_exec
// Next-state logic: applies one instruction to the register set.
// ----------------------------------------------------------------------------
module crfu_exec (
  input  crfu_pkg::in_item_t  item_i,
  input  crfu_pkg::out_item_t cur_i,
  output crfu_pkg::out_item_t nxt_o
);

  crfu_pkg::out_item_t n;
  logic [15:0]         src_val;
  logic [15:0]         dst_val;
  logic [15:0]         xfer_val;
  logic [7:0]          rep_mask;
  logic                regs_ok;

  assign src_val  = crfu_pkg::read_reg(cur_i, item_i.source_reg);
  assign dst_val  = crfu_pkg::read_reg(cur_i, item_i.dest_reg);
  assign regs_ok  = crfu_pkg::reg_sel_ok(item_i.source_reg) &&
                    crfu_pkg::reg_sel_ok(item_i.dest_reg);
  assign rep_mask = ~item_i.operand_byte |
                    (cur_i.emulation ? crfu_pkg::ModeFlagMask : 8'h00);

  always_comb begin
    n        = cur_i;
    xfer_val = src_val;
    case (crfu_pkg::cmd_e'(item_i.cmd))
      crfu_pkg::CMD_XBA: begin
        n.acc                   = {cur_i.acc[7:0], cur_i.acc[15:8]};
        n.status[crfu_pkg::FlagN] = cur_i.acc[15];
        n.status[crfu_pkg::FlagZ] = (cur_i.acc[15:8] == 8'h00);
      end
      crfu_pkg::CMD_XCE: begin
        n.status[crfu_pkg::FlagC] = cur_i.emulation;
        n.emulation               = cur_i.status[crfu_pkg::FlagC];
        if (cur_i.status[crfu_pkg::FlagC]) begin
          n.status    = n.status | crfu_pkg::ModeFlagMask;
          n.stack_ptr = {crfu_pkg::EmuStackPage, cur_i.stack_ptr[7:0]};
          n.index_x   = {8'h00, cur_i.index_x[7:0]};
          n.index_y   = {8'h00, cur_i.index_y[7:0]};
        end
      end
      crfu_pkg::CMD_REP: n.status = cur_i.status & rep_mask;
      crfu_pkg::CMD_SEP: begin
        n.status = cur_i.status | item_i.operand_byte;
        if (n.status[crfu_pkg::FlagX]) begin
          n.index_x = {8'h00, cur_i.index_x[7:0]};
          n.index_y = {8'h00, cur_i.index_y[7:0]};
        end
      end
      crfu_pkg::CMD_CLC: n.status[crfu_pkg::FlagC] = 1'b0;
      crfu_pkg::CMD_SEC: n.status[crfu_pkg::FlagC] = 1'b1;
      crfu_pkg::CMD_CLI: n.status[crfu_pkg::FlagI] = 1'b0;
      crfu_pkg::CMD_SEI: n.status[crfu_pkg::FlagI] = 1'b1;
      crfu_pkg::CMD_CLV: n.status[crfu_pkg::FlagV] = 1'b0;
      crfu_pkg::CMD_CLD: n.status[crfu_pkg::FlagD] = 1'b0;
      crfu_pkg::CMD_SED: n.status[crfu_pkg::FlagD] = 1'b1;
      crfu_pkg::CMD_XFER_BYTE: begin
        if (regs_ok) begin
          // high byte of the destination is kept
          xfer_val = {dst_val[15:8], src_val[7:0]};
          n = crfu_pkg::write_reg(cur_i, item_i.dest_reg, xfer_val);
          n.status[crfu_pkg::FlagN] = xfer_val[7];
          n.status[crfu_pkg::FlagZ] = (xfer_val[7:0] == 8'h00);
        end
      end
      crfu_pkg::CMD_XFER_WORD: begin
        if (regs_ok) begin
          n = crfu_pkg::write_reg(cur_i, item_i.dest_reg, src_val);
          n.status[crfu_pkg::FlagN] = src_val[15];
          n.status[crfu_pkg::FlagZ] = (src_val == 16'h0000);
        end
      end
      crfu_pkg::CMD_TCS: begin
        n.stack_ptr = cur_i.emulation ?
                      {crfu_pkg::EmuStackPage, cur_i.acc[7:0]} : cur_i.acc;
      end
      crfu_pkg::CMD_TSX_BYTE: begin
        n.index_x                 = {cur_i.index_x[15:8], cur_i.stack_ptr[7:0]};
        n.status[crfu_pkg::FlagN] = cur_i.stack_ptr[7];
        n.status[crfu_pkg::FlagZ] = (cur_i.stack_ptr[7:0] == 8'h00);
      end
      crfu_pkg::CMD_TSX_WORD: begin
        n.index_x                 = cur_i.stack_ptr;
        n.status[crfu_pkg::FlagN] = cur_i.stack_ptr[15];
        n.status[crfu_pkg::FlagZ] = (cur_i.stack_ptr == 16'h0000);
      end
      crfu_pkg::CMD_TXS: begin
        n.stack_ptr = cur_i.emulation ?
                      {crfu_pkg::EmuStackPage, cur_i.index_x[7:0]} : cur_i.index_x;
      end
      crfu_pkg::CMD_WRITE: begin
        if (crfu_pkg::reg_sel_ok(item_i.dest_reg)) begin
          n = crfu_pkg::write_reg(cur_i, item_i.dest_reg, item_i.write_value);
        end
      end
      default: n = cur_i;
    endcase
  end

  assign nxt_o = n;

endmodule
